FILE: src/fsbc_pkg.sv
// ----------------------------------------------------------------------------
// fsbc_pkg: shared definitions for the frustum sphere/box cull block
// Number format, request and verdict codes, sequencer states and derived
// widths of the plane build datapath.
// ----------------------------------------------------------------------------
package fsbc_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int PLANE_CNT  = 6;
	localparam int NUM_ROWS   = 4;
	localparam int WORD_W     = 32;
	localparam int ROW_BITS   = 4 * WORD_W;
	localparam int ACC_W      = 67;
	localparam int DIV_W      = 33 + FRAC_BITS;
	localparam int DIV_CNT_W  = $clog2(DIV_W);
	localparam int SQRT_STEPS = 32;
	localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);

	localparam logic [1:0] ROW_IDX_W = 2'd3;

	typedef enum logic [1:0] {
		REQ_LOAD   = 2'd0,
		REQ_SPHERE = 2'd1,
		REQ_BOX    = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	localparam logic [1:0] VERDICT_INSIDE    = 2'd0;
	localparam logic [1:0] VERDICT_INTERSECT = 2'd1;
	localparam logic [1:0] VERDICT_OUTSIDE   = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TEST,
		ST_DONE,
		ST_BW,
		ST_BR,
		ST_BC,
		ST_HALF,
		ST_SQ,
		ST_SQRT,
		ST_DIV,
		ST_PW
	} state_t;

endpackage

FILE: src/fsbc_ram.sv
// ----------------------------------------------------------------------------
// fsbc_ram: generic single-write, single-read synchronous RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fsbc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: src/frustum_sphere_box_cull.sv
// ----------------------------------------------------------------------------
// frustum_sphere_box_cull: view-frustum culling with plane extraction
// Test: six plane reads go through the single plane RAM port (one plane per
// cycle) into the two-stage multiply/compare pipeline, then the verdict is
// finished and handed off to the result register; the next transaction is
// accepted only after that hand-off, and a stalled result holds the following
// test in its verdict stage.
// Matrix load: input ready again only after all six planes are rebuilt, each
// through its halving steps, the 32-step square root and the bit-serial divider;
// a plane with a zero normal skips the divider. Reset clears all control
// state; both stores read as zero until written (per-row valid bits), so no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module frustum_sphere_box_cull (
	input  logic         clk,
	input  logic         arst_n,
	// slave side
	input  logic         s_tvalid,
	output logic         s_tready,
	// tdata: a_x[31:0], a_y, a_z, row_w, b_x, b_y, b_z (224 bits)
	input  logic [223:0] s_tdata,
	// tuser: req_type[1:0], row_index[3:2]
	input  logic [3:0]   s_tuser,
	// master side
	output logic         m_tvalid,
	input  logic         m_tready,
	// tdata: verdict[1:0], zero fill
	output logic [7:0]   m_tdata
);

	import fsbc_pkg::*;

	// ---------------------------------------------------------------- helpers
	// magnitude at least 2^31 on a 33-bit sum
	function automatic logic is_big(input logic signed [32:0] c);
		return (c[32] != c[31]) || (c == {2'b11, 31'd0});
	endfunction

	// halve, truncating toward zero
	function automatic logic signed [32:0] halve(input logic signed [32:0] c);
		logic signed [32:0] t;
		t = c + $signed({32'd0, c[32]});
		return t >>> 1;
	endfunction

	function automatic logic [32:0] mag33(input logic signed [32:0] c);
		return c[32] ? 33'(-c) : 33'(c);
	endfunction

	// ---------------------------------------------------------------- state
	state_t state_q, state_d;

	req_t               req_q;
	logic signed [31:0] a_q [3];
	logic signed [31:0] b_q [3];
	logic [32:0]        rad_q;

	logic [NUM_ROWS-1:0]  mvalid_q;
	logic [PLANE_CNT-1:0] pvalid_q;

	// matrix RAM: one row (x,y,z,w) per entry
	logic                m_we;
	logic [1:0]          m_waddr, m_raddr;
	logic [ROW_BITS-1:0] m_wdata, m_rdata, m_row;
	logic                mrd_ok_q;

	// plane RAM: one plane (x,y,z,w) per entry
	logic                p_we;
	logic [2:0]          p_waddr, p_raddr;
	logic [ROW_BITS-1:0] p_wdata, p_rdata, p_row;
	logic                prd_ok_q;

	// plane build
	logic [2:0]                 plane_q;
	logic signed [31:0]         wrow_q [4];
	logic signed [32:0]         c_q [4];
	logic [1:0]                 sq_k_q;
	logic [63:0]                sum_q;
	logic [63:0]                sqn_q, sqr_q, sqb_q;
	logic [SQRT_CNT_W-1:0]      sq_cnt_q;
	logic [31:0]                len_q;
	logic [1:0]                 dk_q;
	logic [31:0]                rem_q;
	logic [DIV_W-1:0]           dq_q;
	logic [DIV_CNT_W-1:0]       dcnt_q;
	logic [31:0]                coef_q [4];

	// test pipeline
	logic [2:0]               rd_p_q;
	logic                     v_s1, last_s1, v_s2, last_s2;
	logic signed [63:0]       prod_s2 [3];
	logic signed [ACC_W-1:0]  wt_s2;
	logic                     out_flag_q, isect_flag_q;

	logic       m_tvalid_q;
	logic [1:0] verdict_q;

	// ---------------------------------------------------------------- input unpack
	logic               in_fire;
	req_t               in_req;
	logic [1:0]         in_row;
	logic signed [31:0] in_a [3];
	logic signed [31:0] in_b [3];
	logic [32:0]        in_bm [3];
	logic [32:0]        in_rad;

	assign in_fire = s_tvalid && s_tready;
	assign in_req  = req_t'(s_tuser[1:0]);
	assign in_row  = s_tuser[3:2];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			in_a[k]  = s_tdata[32*k +: 32];
			in_b[k]  = s_tdata[128 + 32*k +: 32];
			in_bm[k] = mag33(33'(in_b[k]));
		end
		in_rad = in_bm[0];
		if (in_bm[1] > in_rad) begin
			in_rad = in_bm[1];
		end
		if (in_bm[2] > in_rad) begin
			in_rad = in_bm[2];
		end
	end

	// ---------------------------------------------------------------- memories
	fsbc_ram #(.WIDTH(ROW_BITS), .DEPTH(NUM_ROWS)) u_matrix_ram (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr),
		.wdata (m_wdata),
		.raddr (m_raddr),
		.rdata (m_rdata)
	);

	fsbc_ram #(.WIDTH(ROW_BITS), .DEPTH(PLANE_CNT)) u_plane_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	// rows never written read as zero
	assign m_row = mrd_ok_q ? m_rdata : '0;
	assign p_row = prd_ok_q ? p_rdata : '0;

	// ---------------------------------------------------------------- datapath comb
	// square of one normal component
	logic [32:0] sq_mag;
	logic [61:0] sq_prod;
	logic [63:0] sum_d;
	assign sq_mag  = mag33(c_q[sq_k_q]);
	assign sq_prod = sq_mag[30:0] * sq_mag[30:0];
	assign sum_d   = sum_q + 64'(sq_prod);

	// one step of the bitwise integer square root
	logic [63:0] sq_t, sqn_d, sqr_d;
	logic        sq_ge;
	assign sq_t  = sqr_q + sqb_q;
	assign sq_ge = sqn_q >= sq_t;
	assign sqn_d = sq_ge ? sqn_q - sq_t : sqn_q;
	assign sqr_d = sq_ge ? (sqr_q >> 1) + sqb_q : sqr_q >> 1;

	// one step of the restoring divider
	logic [32:0]      rem_sh, rem_n;
	logic             div_ge;
	logic [DIV_W-1:0] dq_d;
	assign rem_sh = {rem_q, dq_q[DIV_W-1]};
	assign div_ge = rem_sh >= {1'b0, len_q};
	assign rem_n  = div_ge ? rem_sh - {1'b0, len_q} : rem_sh;
	assign dq_d   = {dq_q[DIV_W-2:0], div_ge};

	// saturate the finished quotient with the sign of its coefficient
	logic [31:0] coef_d;
	always_comb begin
		if (c_q[dk_q][32]) begin
			coef_d = (dq_d > DIV_W'(33'h0_8000_0000)) ? 32'h8000_0000 : 32'(-dq_d);
		end else begin
			coef_d = (dq_d > DIV_W'(33'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF : dq_d[31:0];
		end
	end

	logic half_big;
	assign half_big = is_big(c_q[0]) || is_big(c_q[1]) || is_big(c_q[2]);

	// stage 1 operands: plane coefficient against center, min or max corner
	logic signed [31:0] pl_n [3];
	logic signed [31:0] pl_op [3];
	logic signed [31:0] pl_w;
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			pl_n[k]  = p_row[32*k +: 32];
			pl_op[k] = (req_q == REQ_BOX && pl_n[k] > 0) ? b_q[k] : a_q[k];
		end
		pl_w = p_row[96 +: 32];
	end

	// stage 2 sum and compare
	logic signed [ACC_W-1:0] acc, lim;
	logic                    cmp_out, cmp_isect;
	always_comb begin
		acc = ACC_W'(prod_s2[0]) + ACC_W'(prod_s2[1]) + ACC_W'(prod_s2[2]);
		lim = $signed(ACC_W'(rad_q) << FRAC_BITS);
		cmp_out   = 1'b0;
		cmp_isect = 1'b0;
		if (req_q == REQ_BOX) begin
			cmp_out = acc < -wt_s2;
		end else begin
			cmp_out   = (acc + wt_s2) < -lim;
			cmp_isect = (acc + wt_s2) < lim;
		end
	end

	// ---------------------------------------------------------------- next state
	logic issue, done_fire;
	assign issue     = (state_q == ST_TEST) && (rd_p_q < 3'(PLANE_CNT));
	assign done_fire = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					priority if (in_req == REQ_LOAD) state_d = ST_BW;
					else if (in_req == REQ_SPHERE || in_req == REQ_BOX) state_d = ST_TEST;
					else state_d = ST_IDLE;
				end
			end
			ST_TEST: if (v_s2 && last_s2) state_d = ST_DONE;
			ST_DONE: if (done_fire) state_d = ST_IDLE;
			ST_BW:   state_d = ST_BR;
			ST_BR:   state_d = ST_BC;
			ST_BC:   state_d = ST_HALF;
			ST_HALF: if (!half_big) state_d = ST_SQ;
			ST_SQ:   if (sq_k_q == 2'd2) state_d = ST_SQRT;
			ST_SQRT: begin
				if (sq_cnt_q == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
					state_d = (sqr_d == '0) ? ST_PW : ST_DIV;
				end
			end
			ST_DIV: begin
				if (dcnt_q == DIV_CNT_W'(DIV_W - 1) && dk_q == 2'd3) state_d = ST_PW;
			end
			ST_PW:   state_d = (plane_q == 3'(PLANE_CNT - 1)) ? ST_IDLE : ST_BR;
			default: state_d = ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------- control outputs
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		// write a matrix row straight from the load transaction
		m_we    = in_fire && (in_req == REQ_LOAD);
		m_waddr = in_row;
		m_wdata = s_tdata[ROW_BITS-1:0];
		m_raddr = (state_q == ST_BW) ? ROW_IDX_W : plane_q[2:1];
		// write a finished plane; a zero-length normal stores all zero
		p_we    = (state_q == ST_PW);
		p_waddr = plane_q;
		p_wdata = (len_q == '0) ? '0 : {coef_q[3], coef_q[2], coef_q[1], coef_q[0]};
		p_raddr = issue ? rd_p_q : '0;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, verdict_q};

	// ---------------------------------------------------------------- control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mvalid_q   <= '0;
			pvalid_q   <= '0;
			mrd_ok_q   <= 1'b0;
			prd_ok_q   <= 1'b0;
			plane_q    <= '0;
			rd_p_q     <= '0;
			v_s1       <= 1'b0;
			last_s1    <= 1'b0;
			v_s2       <= 1'b0;
			last_s2    <= 1'b0;
			sq_k_q     <= '0;
			sq_cnt_q   <= '0;
			dk_q       <= '0;
			dcnt_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			mrd_ok_q <= mvalid_q[m_raddr];
			prd_ok_q <= pvalid_q[p_raddr];
			if (m_we) begin
				mvalid_q[m_waddr] <= 1'b1;
			end
			if (p_we) begin
				pvalid_q[p_waddr] <= 1'b1;
			end

			// test pipeline: issue one plane read per cycle
			v_s1    <= issue;
			last_s1 <= issue && (rd_p_q == 3'(PLANE_CNT - 1));
			v_s2    <= v_s1;
			last_s2 <= last_s1;
			if (in_fire) begin
				rd_p_q  <= '0;
				plane_q <= '0;
			end else if (issue) begin
				rd_p_q <= rd_p_q + 3'd1;
			end

			// build sequencing
			if (state_q == ST_HALF) begin
				sq_k_q <= '0;
			end else if (state_q == ST_SQ) begin
				sq_k_q <= sq_k_q + 2'd1;
			end
			if (state_q == ST_SQRT) begin
				sq_cnt_q <= sq_cnt_q + SQRT_CNT_W'(1);
			end else begin
				sq_cnt_q <= '0;
			end
			if (state_q == ST_DIV) begin
				if (dcnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					dcnt_q <= '0;
					dk_q   <= dk_q + 2'd1;
				end else begin
					dcnt_q <= dcnt_q + DIV_CNT_W'(1);
				end
			end else begin
				dcnt_q <= '0;
				dk_q   <= '0;
			end
			if (state_q == ST_PW) begin
				plane_q <= plane_q + 3'd1;
			end

			// result register: hold until taken
			if (done_fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_q        <= in_req;
			a_q          <= in_a;
			b_q          <= in_b;
			rad_q        <= in_rad;
			out_flag_q   <= 1'b0;
			isect_flag_q <= 1'b0;
		end

		// stage 1: products of coefficients and operands
		if (v_s1) begin
			for (int k = 0; k < 3; k++) begin
				prod_s2[k] <= pl_n[k] * pl_op[k];
			end
			wt_s2 <= ACC_W'(pl_w) <<< FRAC_BITS;
		end
		// stage 2: accumulate the verdict; outside dominates
		if (v_s2) begin
			out_flag_q   <= out_flag_q | cmp_out;
			isect_flag_q <= isect_flag_q | cmp_isect;
		end

		if (done_fire) begin
			priority if (out_flag_q) verdict_q <= VERDICT_OUTSIDE;
			else if (isect_flag_q) verdict_q <= VERDICT_INTERSECT;
			else verdict_q <= VERDICT_INSIDE;
		end

		unique case (state_q)
			ST_BR: begin
				// first plane: row W arrives from the read issued before
				if (plane_q == '0) begin
					for (int k = 0; k < 4; k++) begin
						wrow_q[k] <= m_row[32*k +: 32];
					end
				end
			end
			ST_BC: begin
				for (int k = 0; k < 4; k++) begin
					if (plane_q[0]) begin
						c_q[k] <= 33'(wrow_q[k]) - 33'($signed(m_row[32*k +: 32]));
					end else begin
						c_q[k] <= 33'(wrow_q[k]) + 33'($signed(m_row[32*k +: 32]));
					end
				end
			end
			ST_HALF: begin
				// scale down until the normal fits 31 magnitude bits
				if (half_big) begin
					for (int k = 0; k < 4; k++) begin
						c_q[k] <= halve(c_q[k]);
					end
				end
				sum_q <= '0;
			end
			ST_SQ: begin
				sum_q <= sum_d;
				sqn_q <= sum_d;
				sqr_q <= '0;
				sqb_q <= 64'h4000_0000_0000_0000;
			end
			ST_SQRT: begin
				sqn_q <= sqn_d;
				sqr_q <= sqr_d;
				sqb_q <= sqb_q >> 2;
				len_q <= sqr_d[31:0];
				rem_q <= '0;
				dq_q  <= {mag33(c_q[0]), FRAC_BITS'(0)};
			end
			ST_DIV: begin
				if (dcnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					coef_q[dk_q] <= coef_d;
					rem_q        <= '0;
					dq_q         <= {mag33(c_q[dk_q + 2'd1]), FRAC_BITS'(0)};
				end else begin
					rem_q <= rem_n[31:0];
					dq_q  <= dq_d;
				end
			end
			ST_IDLE, ST_TEST, ST_DONE, ST_BW, ST_PW: begin
			end
			default: begin
			end
		endcase
	end

	// ---------------------------------------------------------------- assertions
	a_no_plane_write_in_test: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TEST) |-> !p_we)
		else $error("plane store written during a test");

	a_pipe_only_in_test: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (state_q == ST_TEST))
		else $error("test pipeline active outside a test");

	a_div_nonzero_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (len_q != '0))
		else $error("division by a zero normal length");

	a_normal_scaled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQ) |-> !(is_big(c_q[0]) || is_big(c_q[1]) || is_big(c_q[2])))
		else $error("normal not scaled below 2^31 before squaring");

	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_we |=> (state_q == ST_BW))
		else $error("matrix load did not start a plane build");

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for frustum_sphere_box_cull
// Streams matrix row loads and sphere/box tests into the block. A scoreboard
// keeps its own copy of the matrix and planes, rebuilds the planes after
// every load, predicts each verdict and compares it with the master side.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import fsbc_pkg::*;

	localparam int  HALF_PERIOD = 4;
	localparam int  RANDOM_ITEMS = 950;
	localparam int  LOAD_DRAIN = 1500;       // covers a full plane rebuild after a row load
	localparam longint CYCLE_LIMIT = 8000000;

	typedef logic signed [79:0] wide_t;

	// Scoreboard: mirrors the matrix and plane stores, holds pending verdicts.
	class cull_scoreboard;
		int          matrix[16];
		int          planes[24];
		logic [1:0]  verdicts[$];
		int          errors;

		function new();
			foreach (matrix[i]) matrix[i] = 0;
			foreach (planes[i]) planes[i] = 0;
			errors = 0;
		endfunction

		static function longint magnitude(longint v);
			return (v < 0) ? -v : v;
		endfunction

		static function bit [63:0] int_sqrt(bit [63:0] n);
			bit [63:0] r, bt;
			r = 0;
			bt = 64'd1 << 62;
			while (bt > n) bt = bt >> 2;
			while (bt != 0) begin
				if (n >= r + bt) begin
					n = n - (r + bt);
					r = (r >> 1) + bt;
				end else begin
					r = r >> 1;
				end
				bt = bt >> 2;
			end
			return r;
		endfunction

		static function int scale(longint c, bit [63:0] len);
			bit [63:0] q;
			q = (unsigned'(magnitude(c)) << FRAC_BITS) / len;
			if (c < 0) return (q > 64'h8000_0000) ? 32'h8000_0000 : int'(-longint'(q));
			return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : int'(q);
		endfunction

		// Rebuild all six planes as rowW +/- rowX, rowY, rowZ, normalized.
		function void rebuild_planes();
			longint    c[4];
			bit [63:0] sum, len;
			for (int p = 0; p < PLANE_CNT; p++) begin
				for (int k = 0; k < 4; k++)
					c[k] = p[0] ? longint'(matrix[12 + k]) - longint'(matrix[(p >> 1) * 4 + k])
					            : longint'(matrix[12 + k]) + longint'(matrix[(p >> 1) * 4 + k]);
				// halve all four together until the normal fits 31 magnitude bits
				while (magnitude(c[0]) >= 64'sh8000_0000 || magnitude(c[1]) >= 64'sh8000_0000 ||
				       magnitude(c[2]) >= 64'sh8000_0000)
					for (int k = 0; k < 4; k++) c[k] = c[k] / 2;
				sum = unsigned'(c[0] * c[0]) + unsigned'(c[1] * c[1]) +
				      unsigned'(c[2] * c[2]);
				len = int_sqrt(sum);
				for (int k = 0; k < 4; k++)
					planes[p * 4 + k] = (len == 0) ? 0 : scale(c[k], len);
			end
		endfunction

		// Note an accepted input transaction and queue its expected verdict.
		function void note_request(logic [3:0] user, logic [223:0] data);
			int         f[7];
			req_t       req;
			logic [1:0] row, v;
			wide_t      lim, dot, n;
			longint     r;
			req = req_t'(user[1:0]);
			row = user[3:2];
			for (int i = 0; i < 7; i++) f[i] = data[32 * i +: 32];
			case (req)
				REQ_LOAD: begin
					for (int k = 0; k < 4; k++) matrix[row * 4 + k] = f[k];
					rebuild_planes();
					return;
				end
				REQ_SPHERE: begin
					r = 0;
					for (int k = 0; k < 3; k++)
						if (magnitude(f[4 + k]) > r) r = magnitude(f[4 + k]);
					lim = wide_t'(r) <<< FRAC_BITS;
					v = VERDICT_INSIDE;
					for (int p = 0; p < PLANE_CNT; p++) begin
						dot = wide_t'(planes[p * 4 + 3]) <<< FRAC_BITS;
						for (int k = 0; k < 3; k++)
							dot += wide_t'(planes[p * 4 + k]) * wide_t'(f[k]);
						if (dot < -lim) begin
							v = VERDICT_OUTSIDE;
							break;
						end else if (dot < lim) begin
							v = VERDICT_INTERSECT;
						end
					end
					verdicts.push_back(v);
				end
				REQ_BOX: begin
					v = VERDICT_INSIDE;
					for (int p = 0; p < PLANE_CNT; p++) begin
						dot = 0;
						for (int k = 0; k < 3; k++) begin
							n = wide_t'(planes[p * 4 + k]);
							// positive vertex: max corner along a positive normal
							dot += n * ((n > 0) ? wide_t'(f[4 + k]) : wide_t'(f[k]));
						end
						if (dot < -(wide_t'(planes[p * 4 + 3]) <<< FRAC_BITS)) begin
							v = VERDICT_OUTSIDE;
							break;
						end
					end
					verdicts.push_back(v);
				end
				default: ;  // undefined request: dropped by the block
			endcase
		endfunction

		task report_mismatch(string what, logic [1:0] got, logic [1:0] want);
			errors++;
			$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		endtask

		// Check one accepted result transaction against the oldest expectation.
		task check_verdict(logic [7:0] data);
			logic [1:0] want;
			if (verdicts.size() == 0) begin
				report_mismatch("unexpected verdict", data[1:0], 2'd0);
				return;
			end
			want = verdicts.pop_front();
			if (data[1:0] !== want) report_mismatch("verdict", data[1:0], want);
			if (data[7:2] !== '0) report_mismatch("zero fill", data[1:0], want);
		endtask
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [223:0] s_tdata = '0;
	logic [3:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [7:0]   m_tdata;

	cull_scoreboard scoreboard = new();
	int             send_idle_pct = 0;
	int             recv_stall_pct = 0;
	longint         cycles = 0;

	frustum_sphere_box_cull dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #HALF_PERIOD clk = ~clk;

	// Watchdog: end the run if the block stops making progress.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Receiver: stall at random according to the current phase.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Monitor: check results first, then note the input accepted at this edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) scoreboard.check_verdict(m_tdata);
			if (s_tvalid && s_tready) scoreboard.note_request(s_tuser, s_tdata);
		end
	end

	// Drive one input transaction and hold it until the block accepts it.
	task automatic send_item(req_t req, logic [1:0] row, int ax, int ay, int az, int w,
	                         int bx, int by, int bz);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= {row, req};
		s_tdata  <= {bz, by, bx, w, az, ay, ax};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (scoreboard.verdicts.size() != 0) @(posedge clk);
		repeat (LOAD_DRAIN) @(posedge clk);
	endtask

	// Mix of small frustum-scale values, full-range words and extremes.
	function automatic int rand_word();
		int sel;
		sel = $urandom_range(99);
		if (sel < 50) return $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
		if (sel < 80) return $urandom;
		case ($urandom_range(4))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 0;
			3: return 1;
			default: return -1;
		endcase
	endfunction

	task automatic send_random();
		int   sel;
		req_t req;
		sel = $urandom_range(99);
		if (sel < 6) req = REQ_LOAD;
		else if (sel < 8) req = REQ_NONE;
		else if (sel < 54) req = REQ_SPHERE;
		else req = REQ_BOX;
		send_item(req, 2'($urandom_range(3)), rand_word(), rand_word(), rand_word(),
		          rand_word(), rand_word(), rand_word(), rand_word());
	endtask

	localparam int ONE = 1 << FRAC_BITS;

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset planes are all zero, so tests see a zero-normal frustum.
		send_item(REQ_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0);
		send_item(REQ_SPHERE, 0, 5, 5, 5, 0, -ONE, 3, 2);
		send_item(REQ_BOX, 0, -ONE, -ONE, -ONE, 0, ONE, ONE, ONE);
		send_item(REQ_NONE, 3, -1, -1, -1, -1, -1, -1, -1);
		// Identity matrix: clip cube from -1 to 1 on every axis.
		send_item(REQ_LOAD, 0, ONE, 0, 0, 0, 0, 0, 0);
		send_item(REQ_LOAD, 1, 0, ONE, 0, 0, 0, 0, 0);
		send_item(REQ_LOAD, 2, 0, 0, ONE, 0, 0, 0, 0);
		send_item(REQ_LOAD, 3, 0, 0, 0, ONE, 0, 0, 0);
		send_item(REQ_SPHERE, 0, 0, 0, 0, 0, ONE / 4, 0, 0);             // inside
		send_item(REQ_SPHERE, 0, ONE, 0, 0, 0, 0, ONE / 2, 0);           // intersect
		send_item(REQ_SPHERE, 0, 0, 0, 3 * ONE, 0, 0, 0, -ONE);          // outside
		send_item(REQ_BOX, 0, -ONE / 2, -ONE / 2, -ONE / 2, 0, ONE / 2, ONE / 2, ONE / 2);
		send_item(REQ_BOX, 0, 2 * ONE, 0, 0, 0, 3 * ONE, ONE, ONE);      // outside
		send_item(REQ_BOX, 0, ONE, ONE, ONE, 0, -ONE, -ONE, -ONE);       // inverted box
		send_item(REQ_SPHERE, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0,
		          32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		send_item(REQ_BOX, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0,
		          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		// Saturation: tiny normal with a huge distance, both signs.
		send_item(REQ_LOAD, 0, 1, 0, 0, 0, 0, 0, 0);
		send_item(REQ_LOAD, 3, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0);
		send_item(REQ_SPHERE, 0, ONE, ONE, ONE, 0, ONE, 0, 0);
		send_item(REQ_LOAD, 3, 0, 0, 0, 32'h8000_0000, 0, 0, 0);
		send_item(REQ_BOX, 0, -ONE, -ONE, -ONE, 0, ONE, ONE, ONE);
		// Halving: sums of extreme rows overflow 32 bits.
		send_item(REQ_LOAD, 3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
		          0, 0, 0);
		send_item(REQ_LOAD, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
		          0, 0, 0);
		send_item(REQ_SPHERE, 0, -ONE, ONE, 0, 0, 0, 0, ONE);
		send_item(REQ_BOX, 0, -ONE, -ONE, -ONE, 0, ONE, ONE, ONE);

		// Hold off until every pending verdict has come back.
		drain_results();

		// Random phases: free flow, sender idle, receiver stall, both.
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = (ph == 1) ? 71 : (ph == 3) ? 17 : 0;
			recv_stall_pct = (ph == 2) ? 71 : (ph == 3) ? 17 : 0;
			for (int i = 0; i < RANDOM_ITEMS / 4; i++) send_random();
		end
		send_idle_pct  = 0;
		recv_stall_pct = 0;

		drain_results();
		if (scoreboard.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
